@@ sv/lws_pkg.sv @@
// ----------------------------------------------------------------------------
// lws_pkg
// Shared sizes, types and state codes for the longest window sum block.
// ----------------------------------------------------------------------------
package lws_pkg;

    // sizing
    localparam int MAX_ITEMS  = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IN_W       = 32;
    localparam int SUM_W      = 48;
    localparam int LEN_W      = 11;
    localparam int VAL_W      = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int RAM_AW     = IDX_W + 1;
    localparam int RAM_DEPTH  = 2 ** RAM_AW;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // one finished set waiting for the scan
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             dropped;
    } job_t;

    // prefix store write
    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [SUM_W-1:0]  data;
    } ram_wr_t;

    // scan sequencer states
    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_READ = 4'b0010,
        SC_EVAL = 4'b0100,
        SC_DONE = 4'b1000
    } scan_state_t;

endpackage

@@ sv/lws_ram.sv @@
// ----------------------------------------------------------------------------
// lws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lws_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/lws_front.sv @@
// ----------------------------------------------------------------------------
// lws_front
// Accepts words, builds saturating prefix sums into the free bank of the
// prefix store and hands each finished set to the job queue.
// ----------------------------------------------------------------------------
module lws_front import lws_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [IN_W-1:0] item_value,
    input  logic            last_item,
    input  logic            q_full,
    output logic            busy,
    output ram_wr_t         ram_wr,
    output logic            job_push,
    output job_t            job
);

    logic [SUM_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             dropped_reg, dropped_next;
    logic             bank_reg, bank_next;

    logic             accept;
    logic             store_ok;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] sum_sat;

    // handshake: stall only when both banks wait for the scan
    assign busy   = q_full;
    assign accept = start & ~q_full;

    // saturating running total
    assign store_ok = (held_reg < CNT_W'(MAX_ITEMS));
    assign sum_ext  = {1'b0, total_reg} + (SUM_W + 1)'(item_value[VAL_W-1:0]);
    assign sum_sat  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

    // prefix store write
    assign ram_wr.en   = accept & store_ok;
    assign ram_wr.addr = {bank_reg, held_reg[IDX_W-1:0]};
    assign ram_wr.data = sum_sat;

    // job for the scan
    assign job_push    = accept & last_item;
    assign job.bank    = bank_reg;
    assign job.count   = store_ok ? (held_reg + CNT_W'(1)) : held_reg;
    assign job.dropped = dropped_reg | ~store_ok;

    // set bookkeeping
    always_comb
    begin
        total_next   = total_reg;
        held_next    = held_reg;
        dropped_next = dropped_reg;
        bank_next    = bank_reg;
        if (accept)
        begin
            if (last_item)
            begin
                total_next   = '0;
                held_next    = '0;
                dropped_next = 1'b0;
                bank_next    = ~bank_reg;
            end
            else if (store_ok)
            begin
                total_next = sum_sat;
                held_next  = held_reg + CNT_W'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            held_reg    <= '0;
            dropped_reg <= 1'b0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            total_reg   <= total_next;
            held_reg    <= held_next;
            dropped_reg <= dropped_next;
            bank_reg    <= bank_next;
        end
    end

endmodule

@@ sv/lws_job_queue.sv @@
// ----------------------------------------------------------------------------
// lws_job_queue
// Two-entry queue of finished sets; an entry stays at the head until its
// scan is done, so the count is the number of banks owned by the scan.
// ----------------------------------------------------------------------------
module lws_job_queue import lws_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job popped from an empty queue");

endmodule

@@ sv/lws_back.sv @@
// ----------------------------------------------------------------------------
// lws_back
// Two-pointer scan over the prefix sums of the job at the queue head.
// Each pointer step reads both prefix entries, then compares.
// ----------------------------------------------------------------------------
module lws_back import lws_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  job_t              head_job,
    input  logic [SUM_W-1:0]  sum_limit,
    input  logic [SUM_W-1:0]  rd_hi_data,
    input  logic [SUM_W-1:0]  rd_lo_data,
    output logic [RAM_AW-1:0] rd_hi_addr,
    output logic [RAM_AW-1:0] rd_lo_addr,
    output logic              pop,
    output logic              done,
    output logic [LEN_W-1:0]  longest_length,
    output logic              overflowed
);

    scan_state_t      state_reg, state_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic             done_reg, done_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;

    logic [CNT_W-1:0] hi_m1, lo_m1, width_now;
    logic [SUM_W-1:0] start_sum, diff;
    logic             over;

    // prefix entry k sits at index k-1; entry 0 is the implied zero
    assign hi_m1      = hi_reg - CNT_W'(1);
    assign lo_m1      = lo_reg - CNT_W'(1);
    assign rd_hi_addr = {head_job.bank, hi_m1[IDX_W-1:0]};
    assign rd_lo_addr = {head_job.bank, lo_m1[IDX_W-1:0]};

    // window test, a saturated end counts as over the limit
    assign start_sum = (lo_reg == '0) ? '0 : rd_lo_data;
    assign diff      = rd_hi_data - start_sum;
    assign over      = (lo_reg < hi_reg) &&
                       ((rd_hi_data == SUM_MAX) || (diff > sum_limit));
    assign width_now = hi_reg - lo_reg;

    assign pop            = (state_reg == SC_DONE);
    assign done           = done_reg;
    assign longest_length = len_reg;
    assign overflowed     = ovf_reg;

    // scan sequencer
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        best_next  = best_reg;
        done_next  = 1'b0;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            SC_IDLE:
            begin
                if (head_valid)
                begin
                    lo_next   = '0;
                    hi_next   = CNT_W'(1);
                    best_next = '0;
                    if (head_job.count == '0)
                    begin
                        hi_next    = '0;
                        state_next = SC_DONE;
                    end
                    else
                    begin
                        state_next = SC_READ;
                    end
                end
            end
            SC_READ:
            begin
                state_next = SC_EVAL;
            end
            SC_EVAL:
            begin
                if (over)
                begin
                    lo_next    = lo_reg + CNT_W'(1);
                    state_next = SC_READ;
                end
                else
                begin
                    if (width_now > best_reg)
                    begin
                        best_next = width_now;
                    end
                    if (hi_reg == head_job.count)
                    begin
                        state_next = SC_DONE;
                    end
                    else
                    begin
                        hi_next    = hi_reg + CNT_W'(1);
                        state_next = SC_READ;
                    end
                end
            end
            SC_DONE:
            begin
                done_next  = 1'b1;
                len_next   = LEN_W'(best_reg);
                ovf_next   = head_job.dropped;
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            lo_reg    <= '0;
            hi_reg    <= '0;
            best_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            best_reg  <= best_next;
            done_reg  <= done_next;
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        ovf_reg <= ovf_next;
    end

    a_lo_not_past_hi: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("window start passed window end");

    a_best_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != SC_IDLE) |-> (best_reg <= head_job.count))
        else $error("window longer than the set");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == SC_DONE))
        else $error("result word without a finished scan");

endmodule

@@ sv/longest_window_sum_at_most_limit.sv @@
// ----------------------------------------------------------------------------
// longest_window_sum_at_most_limit
// Longest run of consecutive values whose total stays within sum_limit.
// ----------------------------------------------------------------------------
// Words are taken one per clock whenever busy is low. Each set is loaded into
// one of two banks of the prefix store, so a new set can load while the
// previous one is scanned; busy rises only when both banks hold sets still
// waiting for the scan. The scan of a set of n stored values moves two
// pointers at most n times each, each pointer step a prefix read and then
// a compare. The answer for a set waits on done while an earlier set is
// still being scanned. The result word appears on longest_length/overflowed
// as done goes high for a single cycle, cannot be held off and stays until
// the next result. Sets beyond MAX_ITEMS values drop the excess and report
// overflowed. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module longest_window_sum_at_most_limit import lws_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IN_W-1:0]  item_value,
    input  logic             last_item,
    input  logic             cfg_we,
    input  logic [SUM_W-1:0] cfg_data,
    output logic             done,
    output logic [LEN_W-1:0] longest_length,
    output logic             overflowed
);

    logic [SUM_W-1:0]  sum_limit_reg;
    ram_wr_t           ram_wr;
    logic              q_full;
    logic              job_push;
    job_t              push_job;
    logic              pop;
    logic              head_valid;
    job_t              head_job;
    logic [RAM_AW-1:0] rd_hi_addr, rd_lo_addr;
    logic [SUM_W-1:0]  rd_hi_data, rd_lo_data;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            sum_limit_reg <= cfg_data;
        end
    end

    // load side
    lws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item_value (item_value),
        .last_item  (last_item),
        .q_full     (q_full),
        .busy       (busy),
        .ram_wr     (ram_wr),
        .job_push   (job_push),
        .job        (push_job)
    );

    // finished sets
    lws_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // prefix store, one copy per scan pointer
    lws_ram #(.WIDTH(SUM_W), .DEPTH(RAM_DEPTH)) u_ram_hi (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (rd_hi_addr),
        .rd_data (rd_hi_data)
    );

    lws_ram #(.WIDTH(SUM_W), .DEPTH(RAM_DEPTH)) u_ram_lo (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (rd_lo_addr),
        .rd_data (rd_lo_data)
    );

    // scan side
    lws_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_job       (head_job),
        .sum_limit      (sum_limit_reg),
        .rd_hi_data     (rd_hi_data),
        .rd_lo_data     (rd_lo_data),
        .rd_hi_addr     (rd_hi_addr),
        .rd_lo_addr     (rd_lo_addr),
        .pop            (pop),
        .done           (done),
        .longest_length (longest_length),
        .overflowed     (overflowed)
    );

endmodule

@@ tb/tb_longest_window_sum_at_most_limit.sv @@
// ----------------------------------------------------------------------------
// tb_longest_window_sum_at_most_limit
// Self-checking bench for the longest window within a sum limit.
// ----------------------------------------------------------------------------
// Words are sent one set at a time, each set closed by last_item. An internal
// window model keeps its own prefix sums and scans every untyped closed set
// with two pointers, so each answer on done is checked field by field in order.
// A short table of hand-picked words comes first, then random sets under a
// range of limits, then one set that fills and overruns the prefix store.
// ----------------------------------------------------------------------------
module tb_longest_window_sum_at_most_limit;
    import lws_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SCAN_SLACK  = 4 * MAX_ITEMS + 8;
    localparam int RAND_WORDS  = 110;
    localparam int DIR_ROWS    = 24;

    typedef enum logic [0:0] {ROW_WORD, ROW_LIMIT} row_kind_t;
    typedef enum logic [2:0] {RG_SMALL, RG_SPARSE, RG_WIDE, RG_FULL, RG_RAND} regime_t;
    typedef enum logic [1:0] {MIX_SMALL, MIX_SPARSE, MIX_WIDE} value_mix_t;

    // one row of the directed table; typed answers only where obvious
    typedef struct packed {
        row_kind_t        kind;
        logic [SUM_W-1:0] data;
        logic             last;
        logic             typed;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } stim_row_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             ovf;
    } answer_t;

    logic             clk;
    logic             rst_n          = 1'b0;
    logic             start          = 1'b0;
    logic             busy;
    logic [IN_W-1:0]  item_value     = '0;
    logic             last_item      = 1'b0;
    logic             cfg_we         = 1'b0;
    logic [SUM_W-1:0] cfg_data       = '0;
    logic             done;
    logic [LEN_W-1:0] longest_length;
    logic             overflowed;

    // window model state
    logic [SUM_W-1:0] prefix_sums [MAX_ITEMS];
    logic [SUM_W-1:0] run_sum     = '0;
    int unsigned      held_cnt    = 0;
    logic             drop_seen   = 1'b0;
    logic [SUM_W-1:0] limit_model = '0;

    answer_t pending_answers [$];

    bit          gaps_on         = 1'b1;
    int unsigned words_sent      = 0;
    int unsigned sets_ended      = 0;
    int unsigned overflow_sets   = 0;
    int unsigned limit_writes    = 0;
    int unsigned answers_checked = 0;
    int unsigned mismatch_cnt    = 0;
    int unsigned cycle_cnt       = 0;

    stim_row_t dir_tbl [DIR_ROWS] = '{
        // limit 0 after reset: a zero fits, a one does not
        '{ROW_WORD,  48'h0,            1'b1, 1'b1, 11'd1, 1'b0},
        '{ROW_WORD,  48'h1,            1'b1, 1'b1, 11'd0, 1'b0},
        '{ROW_WORD,  48'h0,            1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h5,            1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h0,            1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h0,            1'b1, 1'b0, 11'd0, 1'b0},
        '{ROW_LIMIT, 48'd10,           1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h3,            1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h4,            1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h3,            1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h1,            1'b1, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'hFFFF_FFFF,    1'b1, 1'b1, 11'd0, 1'b0},
        // widest limit: everything fits
        '{ROW_LIMIT, SUM_MAX,          1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'hFFFF_FFFF,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'hFFFF_FFFF,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'hFFFF_FFFF,    1'b1, 1'b1, 11'd3, 1'b0},
        '{ROW_WORD,  48'h0,            1'b1, 1'b1, 11'd1, 1'b0},
        // limit equal to one full value
        '{ROW_LIMIT, 48'hFFFF_FFFF,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'hFFFF_FFFF,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h1,            1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'hFFFF_FFFF,    1'b1, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'hAAAA_AAAA,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h5555_5555,    1'b1, 1'b0, 11'd0, 1'b0},
        '{ROW_WORD,  48'h7,            1'b1, 1'b0, 11'd0, 1'b0}
    };

    longest_window_sum_at_most_limit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item_value     (item_value),
        .last_item      (last_item),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .done           (done),
        .longest_length (longest_length),
        .overflowed     (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // window model
    // ------------------------------------------------------------------
    function automatic logic [SUM_W-1:0] prefix_at(input int unsigned k);
        return (k == 0) ? '0 : prefix_sums[k-1];
    endfunction

    // a window ending on a saturated prefix never fits
    function automatic bit span_over(input int unsigned lo, input int unsigned hi);
        logic [SUM_W-1:0] tail;
        tail = prefix_at(hi);
        if (lo >= hi)
            return 1'b0;
        if (tail == SUM_MAX)
            return 1'b1;
        return (tail - prefix_at(lo)) > limit_model;
    endfunction

    function automatic logic [LEN_W-1:0] longest_fit();
        int unsigned lo;
        int unsigned hi;
        int unsigned best;
        lo   = 0;
        best = 0;
        for (hi = 1; hi <= held_cnt; hi++)
        begin
            while (lo < hi && span_over(lo, hi))
                lo++;
            if (hi - lo > best)
                best = hi - lo;
        end
        return best[LEN_W-1:0];
    endfunction

    // fold one taken word into the model; a closed set queues its answer
    function automatic void absorb_word(input logic [IN_W-1:0] v, input logic l,
                                        input logic typed, input logic [LEN_W-1:0] t_len,
                                        input logic t_ovf);
        logic [SUM_W:0] grown;
        answer_t        ans;
        if (held_cnt < MAX_ITEMS)
        begin
            grown = {1'b0, run_sum} + (SUM_W + 1)'(v[VAL_W-1:0]);
            run_sum = grown[SUM_W] ? SUM_MAX : grown[SUM_W-1:0];
            prefix_sums[held_cnt] = run_sum;
            held_cnt++;
        end
        else
        begin
            drop_seen = 1'b1;
        end
        if (l)
        begin
            ans.len = typed ? t_len : longest_fit();
            ans.ovf = typed ? t_ovf : drop_seen;
            pending_answers.push_back(ans);
            sets_ended++;
            if (drop_seen)
                overflow_sets++;
            run_sum   = '0;
            held_cnt  = 0;
            drop_seen = 1'b0;
        end
    endfunction

    function automatic logic [IN_W-1:0] rand_value(input value_mix_t mix);
        int unsigned     w;
        logic [IN_W-1:0] v;
        case (mix)
            MIX_SMALL:  v = $urandom_range(0, 15);
            MIX_SPARSE: v = ($urandom_range(0, 1) == 0) ? '0 : $urandom_range(1, 3);
            default:
            begin
                w = $urandom_range(1, IN_W);
                v = $urandom >> (IN_W - w);
                if ($urandom_range(0, 15) == 0)
                    v = '1;
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // drivers: every call starts in the step right after a rising edge
    // ------------------------------------------------------------------
    task automatic idle_cycles(input int unsigned n);
        start      <= 1'b0;
        item_value <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    // stop sending, let all answers come back, then extra slack
    task automatic quiesce(input int unsigned slack);
        start <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (slack) @(posedge clk);
    endtask

    task automatic set_limit(input logic [SUM_W-1:0] lim);
        quiesce(SCAN_SLACK);
        cfg_we      <= 1'b1;
        cfg_data    <= lim;
        limit_model = lim;
        limit_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // word is taken at the edge after a low busy seen mid-cycle
    task automatic send_word(input logic [IN_W-1:0] v, input logic l, input logic typed,
                             input logic [LEN_W-1:0] t_len, input logic t_ovf);
        bit taken;
        if (gaps_on && $urandom_range(0, 4) == 0)
            idle_cycles($urandom_range(1, 16));
        start      <= 1'b1;
        item_value <= v;
        last_item  <= l;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if (!busy)
            begin
                taken = 1'b1;
                absorb_word(v, l, typed, t_len, t_ovf);
            end
            @(posedge clk);
        end
        words_sent++;
    endtask

    // ------------------------------------------------------------------
    // answer checker, sampled mid-cycle
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected answer: expected none, actual len %0d ovf %0b",
                         $time, longest_length, overflowed);
            end
            else
            begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (longest_length !== want.len)
                begin
                    mismatch_cnt++;
                    $display("%0t: longest_length expected %0d actual %0d",
                             $time, want.len, longest_length);
                end
                if (overflowed !== want.ovf)
                begin
                    mismatch_cnt++;
                    $display("%0t: overflowed expected %0b actual %0b",
                             $time, want.ovf, overflowed);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d answers still pending", $time,
                     pending_answers.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [SUM_W-1:0] lim;
        regime_t          regime;
        value_mix_t       mix;
        int unsigned      phase;
        int unsigned      rand_words;
        int unsigned      n_sets;
        int unsigned      set_len;
        int unsigned      s;
        int unsigned      k;
        int unsigned      pick;
        int               i;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tbl[i].kind == ROW_LIMIT)
                set_limit(dir_tbl[i].data);
            else
                send_word(dir_tbl[i].data[IN_W-1:0], dir_tbl[i].last, dir_tbl[i].typed,
                          dir_tbl[i].len, dir_tbl[i].ovf);
        end

        // random sets, one limit regime per phase
        phase      = 0;
        rand_words = 0;
        while (rand_words < RAND_WORDS)
        begin
            regime  = regime_t'(phase % 5);
            gaps_on = (phase % 3 != 2) && (rand_words < RAND_WORDS * 3 / 4);
            case (regime)
                RG_SMALL:
                begin
                    lim = SUM_W'($urandom_range(0, 60));
                    mix = MIX_SMALL;
                end
                RG_SPARSE:
                begin
                    lim = '0;
                    mix = MIX_SPARSE;
                end
                RG_WIDE:
                begin
                    lim = {16'($urandom_range(0, 7)), 32'($urandom)};
                    mix = MIX_WIDE;
                end
                RG_FULL:
                begin
                    lim = SUM_MAX;
                    mix = MIX_WIDE;
                end
                default:
                begin
                    lim = {16'($urandom), 32'($urandom)};
                    mix = MIX_WIDE;
                end
            endcase
            set_limit(lim);
            n_sets = $urandom_range(1, 4);
            for (s = 0; s < n_sets && rand_words < RAND_WORDS; s++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    set_len = 1;
                else if (pick == 1)
                    set_len = $urandom_range(25, 80);
                else
                    set_len = $urandom_range(2, 24);
                for (k = 0; k < set_len; k++)
                    send_word(rand_value(mix), k == set_len - 1, 1'b0, '0, 1'b0);
                rand_words += set_len;
                // occasionally hold off until the block has answered everything
                if ($urandom_range(0, 9) == 0)
                    quiesce(0);
            end
            phase++;
        end

        // store full: fill every entry, then end the set on a dropped word
        gaps_on = 1'b0;
        set_limit(SUM_MAX);
        for (k = 0; k < MAX_ITEMS + 2; k++)
            send_word(rand_value(MIX_WIDE), k == MAX_ITEMS + 1, 1'b0, '0, 1'b0);

        quiesce(SCAN_SLACK);

        $display("Sent %0d words in %0d sets under %0d limit settings, %0d sets overran the store",
                 words_sent, sets_ended, limit_writes, overflow_sets);
        $display("Compared %0d answers against the window model", answers_checked);
        if (mismatch_cnt == 0 && pending_answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ longest_window_sum_at_most_limit.f @@
sv/lws_pkg.sv
sv/lws_ram.sv
sv/lws_front.sv
sv/lws_job_queue.sv
sv/lws_back.sv
sv/longest_window_sum_at_most_limit.sv
tb/tb_longest_window_sum_at_most_limit.sv
